// ----- rtl/dgt_pkg.sv -----
// Shared types, constants and helpers for the disk geometry translation block.
`default_nettype none

package dgt_pkg;

    // Field and datapath widths
    localparam int CAP_W     = 32;
    localparam int CYL_W     = 16;
    localparam int IN_HD_W   = 8;
    localparam int HD_W      = 18;
    localparam int SPT_W     = 8;
    localparam int MUL_B_W   = 18;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);
    localparam int DIV_CNT_W = $clog2(CAP_W);
    localparam int TRY_W     = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Register map (word index taken from paddr[2])
    localparam logic REG_METHOD = 1'b0;

    // Translation methods
    localparam logic METHOD_FIXED   = 1'b0;
    localparam logic METHOD_STEPPED = 1'b1;

    // Geometry constants
    localparam logic [CYL_W-1:0] CYL_LIMIT      = 16'd1024;
    localparam logic [CAP_W-1:0] M0_CYLS        = 32'd1024;
    localparam logic [SPT_W-1:0] M0_SPT         = 8'd62;
    localparam logic [CAP_W-1:0] M0_PER_HEAD    = 32'd63488;
    localparam logic [CAP_W-1:0] M1_TRACK_LIMIT = 32'd32768;
    localparam logic [TRY_W-1:0] M1_LAST_TRY    = 2'd2;

    // Input item
    typedef struct packed {
        logic [CYL_W-1:0]   cylinders_in;
        logic [IN_HD_W-1:0] heads_in;
        logic [SPT_W-1:0]   sectors_in;
    } t_geom_in;

    // Result item
    typedef struct packed {
        logic [CYL_W-1:0] cylinders_out;
        logic [HD_W-1:0]  heads_out;
        logic [SPT_W-1:0] sectors_out;
        logic             translated;
    } t_geom_out;

    // Serial multiplier request and status
    typedef struct packed {
        logic               start;
        logic [CAP_W-1:0]   a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             ovf;
        logic [CAP_W-1:0] prod;
    } t_mul_res;

    // Serial divider request and status
    typedef struct packed {
        logic             start;
        logic [CAP_W-1:0] num;
        logic [CAP_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CAP_W-1:0] quot;
        logic [CAP_W-1:0] rem;
    } t_div_res;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAP1,
        ST_CAP2,
        ST_M0_D1,
        ST_M0_D2,
        ST_M0_MUL,
        ST_M0_D3,
        ST_M1_D1,
        ST_M1_MUL1,
        ST_M1_D2,
        ST_M1_MUL2,
        ST_FINISH
    } t_state;

    // Sectors per track tried by the stepped method
    function automatic logic [SPT_W-1:0] m1_spt(input logic [TRY_W-1:0] idx);
        logic [SPT_W-1:0] spt;
        unique case (idx)
            2'd0:    spt = 8'd17;
            2'd1:    spt = 8'd34;
            default: spt = 8'd63;
        endcase
        return spt;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/disk_geometry_translation.sv -----
// Top level: APB method register, sequencer and shared serial multiplier and divider.
// Pass-through item (cylinders at most 1024 or zero capacity): result strobe in the cycle after accept.
// Translation: 2 capacity multiplies, then method 0 takes 1 to 3 divisions, with one multiply
// before the third; method 1 takes 1 to 3 tries of two divisions and two multiplies each.
// The divider produces 1 quotient bit per cycle.
// One item at a time: for a translated item busy stays high until the result strobe. Synchronous reset sets method 0.
`default_nettype none

module disk_geometry_translation (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Command channel
    input  wire                               start,
    output logic                              busy,
    input  dgt_pkg::t_geom_in                 i_geom,
    output logic                              o_done,
    output dgt_pkg::t_geom_out                o_result,
    // Configuration port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [dgt_pkg::PADDR_W-1:0]       paddr,
    input  wire  [dgt_pkg::PDATA_W-1:0]       pwdata,
    output logic [dgt_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    dgt_pkg::t_state r_state, n_state;
    logic            r_launch;
    logic            r_done;
    logic            r_method;

    dgt_pkg::t_geom_in             r_in;
    dgt_pkg::t_geom_out            r_res;
    logic [dgt_pkg::CAP_W-1:0]     r_cap;
    logic [dgt_pkg::CAP_W-1:0]     r_prod;
    logic [dgt_pkg::CAP_W-1:0]     r_cyl;
    logic [dgt_pkg::HD_W-1:0]      r_hd;
    logic [dgt_pkg::SPT_W-1:0]     r_spt;
    logic [dgt_pkg::TRY_W-1:0]     r_try;

    dgt_pkg::t_mul_req mul_req;
    dgt_pkg::t_mul_res mul_res;
    dgt_pkg::t_div_req div_req;
    dgt_pkg::t_div_res div_res;

    logic accept;
    logic need_xlat;
    logic rem_nz;
    logic fits;
    logic cfg_wr;

    // Shared arithmetic units
    dgt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_res   (mul_res)
    );

    dgt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    // Decode accept and the translate condition
    always_comb begin
        busy      = (r_state != dgt_pkg::ST_IDLE);
        accept    = start && !busy;
        need_xlat = (i_geom.cylinders_in > dgt_pkg::CYL_LIMIT)
                    && (i_geom.heads_in != '0) && (i_geom.sectors_in != '0);
        rem_nz    = (div_res.rem != '0);
        fits      = !mul_res.ovf && (mul_res.prod < dgt_pkg::M1_TRACK_LIMIT);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dgt_pkg::ST_IDLE:    if (accept && need_xlat) n_state = dgt_pkg::ST_CAP1;
            dgt_pkg::ST_CAP1:    if (mul_res.done) n_state = dgt_pkg::ST_CAP2;
            dgt_pkg::ST_CAP2: begin
                if (mul_res.done) begin
                    n_state = (r_method == dgt_pkg::METHOD_STEPPED) ? dgt_pkg::ST_M1_D1
                                                                    : dgt_pkg::ST_M0_D1;
                end
            end
            dgt_pkg::ST_M0_D1: begin
                if (div_res.done) n_state = rem_nz ? dgt_pkg::ST_M0_D2 : dgt_pkg::ST_FINISH;
            end
            dgt_pkg::ST_M0_D2: begin
                if (div_res.done) n_state = rem_nz ? dgt_pkg::ST_M0_MUL : dgt_pkg::ST_FINISH;
            end
            dgt_pkg::ST_M0_MUL:  if (mul_res.done) n_state = dgt_pkg::ST_M0_D3;
            dgt_pkg::ST_M0_D3:   if (div_res.done) n_state = dgt_pkg::ST_FINISH;
            dgt_pkg::ST_M1_D1:   if (div_res.done) n_state = dgt_pkg::ST_M1_MUL1;
            dgt_pkg::ST_M1_MUL1: if (mul_res.done) n_state = dgt_pkg::ST_M1_D2;
            dgt_pkg::ST_M1_D2:   if (div_res.done) n_state = dgt_pkg::ST_M1_MUL2;
            dgt_pkg::ST_M1_MUL2: begin
                if (mul_res.done) begin
                    n_state = (fits || r_try == dgt_pkg::M1_LAST_TRY) ? dgt_pkg::ST_FINISH
                                                                      : dgt_pkg::ST_M1_D1;
                end
            end
            dgt_pkg::ST_FINISH:  n_state = dgt_pkg::ST_IDLE;
            default:             n_state = dgt_pkg::ST_IDLE;
        endcase
    end

    // Unit launches and operand selection
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = r_cap;
        mul_req.b     = {{(dgt_pkg::MUL_B_W-dgt_pkg::SPT_W){1'b0}}, r_spt};
        div_req.start = 1'b0;
        div_req.num   = r_cap;
        div_req.den   = r_prod;
        unique case (r_state)
            dgt_pkg::ST_CAP1: begin
                mul_req.start = r_launch;
                mul_req.a     = {{(dgt_pkg::CAP_W-dgt_pkg::CYL_W){1'b0}}, r_in.cylinders_in};
                mul_req.b     = {{(dgt_pkg::MUL_B_W-dgt_pkg::IN_HD_W){1'b0}}, r_in.heads_in};
            end
            dgt_pkg::ST_CAP2: begin
                mul_req.start = r_launch;
                mul_req.b     = {{(dgt_pkg::MUL_B_W-dgt_pkg::SPT_W){1'b0}}, r_in.sectors_in};
            end
            dgt_pkg::ST_M0_MUL, dgt_pkg::ST_M1_MUL1: begin
                mul_req.start = r_launch;
                mul_req.a     = {{(dgt_pkg::CAP_W-dgt_pkg::HD_W){1'b0}}, r_hd};
            end
            dgt_pkg::ST_M1_MUL2: begin
                mul_req.start = r_launch;
                mul_req.a     = r_cyl;
                mul_req.b     = r_hd;
            end
            dgt_pkg::ST_M0_D1: begin
                div_req.start = r_launch;
                div_req.den   = dgt_pkg::M0_PER_HEAD;
            end
            dgt_pkg::ST_M0_D2: begin
                div_req.start = r_launch;
                div_req.den   = {{(dgt_pkg::CAP_W-dgt_pkg::HD_W-10){1'b0}}, r_hd, 10'b0};
            end
            dgt_pkg::ST_M0_D3, dgt_pkg::ST_M1_D2: begin
                div_req.start = r_launch;
            end
            dgt_pkg::ST_M1_D1: begin
                div_req.start = r_launch;
                div_req.num   = {10'b0, r_cap[dgt_pkg::CAP_W-1:10]};
                div_req.den   = {{(dgt_pkg::CAP_W-dgt_pkg::SPT_W){1'b0}}, r_spt};
            end
            default: begin
                mul_req.start = 1'b0;
                div_req.start = 1'b0;
            end
        endcase
    end

    // Control registers: state, launch pulse, result strobe, method, try index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dgt_pkg::ST_IDLE;
            r_launch <= 1'b0;
            r_done   <= 1'b0;
            r_method <= dgt_pkg::METHOD_FIXED;
            r_try    <= '0;
        end else begin
            r_state  <= n_state;
            r_launch <= (n_state != r_state);
            r_done   <= (accept && !need_xlat) || (r_state == dgt_pkg::ST_FINISH);
            if (cfg_wr && paddr[2] == dgt_pkg::REG_METHOD) begin
                r_method <= pwdata[0];
            end
            if (accept) begin
                r_try <= '0;
            end else if (r_state == dgt_pkg::ST_M1_MUL2 && mul_res.done && !fits
                         && r_try != dgt_pkg::M1_LAST_TRY) begin
                r_try <= r_try + 1'b1;
            end
        end
    end

    // Datapath: capture inputs and unit results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in                <= i_geom;
            r_res.cylinders_out <= i_geom.cylinders_in;
            r_res.heads_out     <= {{(dgt_pkg::HD_W-dgt_pkg::IN_HD_W){1'b0}}, i_geom.heads_in};
            r_res.sectors_out   <= i_geom.sectors_in;
            r_res.translated    <= 1'b0;
        end
        unique case (r_state)
            dgt_pkg::ST_CAP1: if (mul_res.done) r_cap <= mul_res.prod;
            dgt_pkg::ST_CAP2: begin
                if (mul_res.done) begin
                    r_cap <= mul_res.prod;
                    r_cyl <= dgt_pkg::M0_CYLS;
                    r_spt <= (r_method == dgt_pkg::METHOD_STEPPED) ? dgt_pkg::m1_spt('0)
                                                                   : dgt_pkg::M0_SPT;
                end
            end
            dgt_pkg::ST_M0_D1: begin
                if (div_res.done) begin
                    r_hd <= div_res.quot[dgt_pkg::HD_W-1:0]
                            + {{(dgt_pkg::HD_W-1){1'b0}}, rem_nz};
                end
            end
            dgt_pkg::ST_M0_D2: begin
                if (div_res.done) begin
                    r_spt <= div_res.quot[dgt_pkg::SPT_W-1:0]
                             + {{(dgt_pkg::SPT_W-1){1'b0}}, rem_nz};
                end
            end
            dgt_pkg::ST_M0_MUL, dgt_pkg::ST_M1_MUL1: begin
                if (mul_res.done) r_prod <= mul_res.prod;
            end
            dgt_pkg::ST_M0_D3, dgt_pkg::ST_M1_D2: begin
                if (div_res.done) r_cyl <= div_res.quot;
            end
            dgt_pkg::ST_M1_D1: begin
                if (div_res.done) begin
                    r_hd <= div_res.quot[dgt_pkg::HD_W-1:0] + dgt_pkg::HD_W'(1);
                end
            end
            dgt_pkg::ST_M1_MUL2: begin
                if (mul_res.done && !fits && r_try != dgt_pkg::M1_LAST_TRY) begin
                    r_spt <= dgt_pkg::m1_spt(r_try + 1'b1);
                end
            end
            dgt_pkg::ST_FINISH: begin
                r_res.cylinders_out <= r_cyl[dgt_pkg::CYL_W-1:0];
                r_res.heads_out     <= r_hd;
                r_res.sectors_out   <= r_spt;
                r_res.translated    <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Configuration port: no wait states, method readback
    always_comb begin
        pready = 1'b1;
        cfg_wr = psel && penable && pwrite && pready;
        prdata = '0;
        if (paddr[2] == dgt_pkg::REG_METHOD) begin
            prdata = {{(dgt_pkg::PDATA_W-1){1'b0}}, r_method};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    // An accepted item either starts work or returns its result next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_done))
        else $error("accepted item neither started nor completed");

    // The two shared units never run at the same time
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_res.busy && div_res.busy))
        else $error("multiplier and divider busy together");

    // A translated geometry has at most 1024 cylinders
    a_translated_cyl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.translated) |-> (o_result.cylinders_out <= dgt_pkg::CYL_LIMIT))
        else $error("translated cylinder count above limit");

    // The stepped method never goes past its last try
    a_try_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_try <= dgt_pkg::M1_LAST_TRY)
        else $error("sector try index out of range");

endmodule

`default_nettype wire

// ----- rtl/dgt_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle, with sticky overflow.
`default_nettype none

module dgt_mul (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  dgt_pkg::t_mul_req i_req,
    output dgt_pkg::t_mul_res o_res
);

    logic [dgt_pkg::CAP_W-1:0]     r_a;
    logic [dgt_pkg::MUL_B_W-1:0]   r_b;
    logic [dgt_pkg::CAP_W-1:0]     r_acc;
    logic                          r_ovf;
    logic [dgt_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [dgt_pkg::CAP_W:0]   n_dbl;
    logic [dgt_pkg::CAP_W+1:0] n_sum;

    // Double the accumulator and add the multiplicand when the top bit is set
    always_comb begin
        n_dbl = {r_acc, 1'b0};
        n_sum = {1'b0, n_dbl} + (r_b[dgt_pkg::MUL_B_W-1] ? {2'b00, r_a}
                                                          : {(dgt_pkg::CAP_W+2){1'b0}});
    end

    // Control: busy for one pass over the multiplier bits, then a done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == dgt_pkg::MUL_CNT_W'(dgt_pkg::MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_b   <= {r_b[dgt_pkg::MUL_B_W-2:0], 1'b0};
            r_acc <= n_sum[dgt_pkg::CAP_W-1:0];
            r_ovf <= r_ovf | (n_sum[dgt_pkg::CAP_W+1:dgt_pkg::CAP_W] != 2'b00);
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.prod = r_acc;

endmodule

`default_nettype wire

// ----- rtl/dgt_div.sv -----
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
`default_nettype none

module dgt_div (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  dgt_pkg::t_div_req i_req,
    output dgt_pkg::t_div_res o_res
);

    logic [dgt_pkg::CAP_W-1:0]     r_num;
    logic [dgt_pkg::CAP_W-1:0]     r_den;
    logic [dgt_pkg::CAP_W-1:0]     r_rem;
    logic [dgt_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [dgt_pkg::CAP_W:0]   n_shift;
    logic [dgt_pkg::CAP_W+1:0] n_diff;
    logic                      n_qbit;

    // Bring down the next dividend bit and trial-subtract the divisor
    always_comb begin
        n_shift = {r_rem, r_num[dgt_pkg::CAP_W-1]};
        n_diff  = {1'b0, n_shift} - {2'b00, r_den};
        n_qbit  = ~n_diff[dgt_pkg::CAP_W+1];
    end

    // Control: busy for one pass over the dividend bits, then a done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == dgt_pkg::DIV_CNT_W'(dgt_pkg::CAP_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[dgt_pkg::CAP_W-2:0], n_qbit};
            r_rem <= n_qbit ? n_diff[dgt_pkg::CAP_W-1:0] : n_shift[dgt_pkg::CAP_W-1:0];
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_done;
    assign o_res.quot = r_num;
    assign o_res.rem  = r_rem;

endmodule

`default_nettype wire
